[design/lbpm_pkg.sv]
// shared types and constants of the log band peak hold meter
`default_nettype none
package lbpm_pkg;

  localparam int COEF_W     = 16;
  localparam int HOLD_W     = 8;
  localparam int ENTRY_W    = 6;
  localparam int BANDNUM_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DECAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SCALE = 2'd2;

  localparam logic [HOLD_W-1:0] HOLD_FRAMES_RST = 8'd30;
  localparam logic [COEF_W-1:0] PEAK_DECAY_RST  = 16'd64225;
  localparam logic [COEF_W-1:0] LEVEL_SCALE_RST = 16'd65529;

  localparam logic OP_MAP_WRITE = 1'b0;
  localparam logic OP_MAGNITUDE = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic take;
    logic acc_rd;
    logic acc_wr;
    logic f_rd;
    logic f_lvl;
    logic f_dec;
    logic f_upd;
  } lbpm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_mag;
    logic frame_end;
    logic band_last;
    logic out_free;
  } lbpm_sts_t;

endpackage
`default_nettype wire

[design/lbpm_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module lbpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[design/lbpm_ctrl.sv]
// sequencer: clear pass, bin accumulation and frame end band walk
`default_nettype none
module lbpm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lbpm_pkg::lbpm_sts_t sts_i,
  output lbpm_pkg::lbpm_cmd_t      cmd_o
);
  import lbpm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MAP, S_ACC, S_FRD, S_FML, S_FMD, S_FUPD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.in_mag) state_d = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.acc_rd = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_wr = 1'b1;
        state_d      = sts_i.frame_end ? S_FRD : S_IDLE;
      end
      S_FRD: begin
        cmd_o.f_rd = 1'b1;
        state_d    = S_FML;
      end
      S_FML: begin
        cmd_o.f_lvl = 1'b1;
        state_d     = S_FMD;
      end
      S_FMD: begin
        cmd_o.f_dec = 1'b1;
        state_d     = S_FUPD;
      end
      S_FUPD: begin
        // hold the band until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.f_upd = 1'b1;
          state_d     = sts_i.band_last ? S_IDLE : S_FRD;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[design/lbpm_dp.sv]
// datapath: band map, band maxima, peak and hold store, shared scaler, output register
`default_nettype none
module lbpm_dp #(
  parameter int NUM_BANDS = 32,
  parameter int NUM_BINS  = 512,
  parameter int MAG_WIDTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lbpm_pkg::lbpm_cmd_t                  cmd_i,
  output lbpm_pkg::lbpm_sts_t                       sts_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lbpm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [lbpm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                 operation_i,
  input  wire logic                                 channel_i,
  input  wire logic [$clog2(NUM_BINS)-1:0]          bin_index_i,
  input  wire logic [lbpm_pkg::ENTRY_W-1:0]         band_entry_i,
  input  wire logic [MAG_WIDTH-1:0]                 magnitude_i,
  input  wire logic                                 frame_end_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      out_channel_o,
  output logic      [lbpm_pkg::BANDNUM_W-1:0]       band_number_o,
  output logic      [MAG_WIDTH-1:0]                 band_level_o,
  output logic      [MAG_WIDTH-1:0]                 band_peak_o,
  output logic                                      last_band_o
);
  import lbpm_pkg::*;

  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int BW         = $clog2(NUM_BANDS);
  localparam int STAT_AW    = BW + 1;
  localparam int STAT_DEPTH = 1 << STAT_AW;
  localparam int CLR_DEPTH  = (NUM_BINS > STAT_DEPTH) ? NUM_BINS : STAT_DEPTH;
  localparam int CLR_W      = $clog2(CLR_DEPTH);
  localparam int PROD_W     = MAG_WIDTH + COEF_W;
  localparam int PEAK_W     = MAG_WIDTH + HOLD_W;

  localparam logic [ENTRY_W-1:0] OUT_OF_RANGE = ENTRY_W'(NUM_BANDS);
  localparam logic [PROD_W-1:0]  ROUND_HALF   = PROD_W'(1) << (COEF_W - 1);

  // configuration
  logic [HOLD_W-1:0] hold_frames_q;
  logic [COEF_W-1:0] peak_decay_q, level_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_frames_q <= HOLD_FRAMES_RST;
      peak_decay_q  <= PEAK_DECAY_RST;
      level_scale_q <= LEVEL_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HOLD_FRAMES: hold_frames_q <= cfg_wdata_i[HOLD_W-1:0];
        CFG_PEAK_DECAY:  peak_decay_q  <= cfg_wdata_i;
        CFG_LEVEL_SCALE: level_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clear sweep counter
  logic [CLR_W-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + CLR_W'(1);
    end
  end

  // latched word
  logic                 ch_q, fend_q, bin_ok_q, hit_q;
  logic [MAG_WIDTH-1:0] mag_q;
  logic [BW-1:0]        band_q;
  logic [STAT_AW-1:0]   acc_addr_q;

  // memories
  logic [ENTRY_W-1:0]   map_rdata;
  logic [MAG_WIDTH-1:0] acc_rdata;
  logic [PEAK_W-1:0]    pk_rdata;

  logic                 map_we;
  logic [BIN_W-1:0]     map_waddr;
  logic [ENTRY_W-1:0]   map_wdata;
  logic                 acc_we, acc_re, pk_we;
  logic [STAT_AW-1:0]   acc_waddr, acc_raddr, pk_waddr;
  logic [MAG_WIDTH-1:0] acc_wdata;
  logic [PEAK_W-1:0]    pk_wdata;
  logic                 bin_ok_in;

  assign bin_ok_in = (bin_index_i != '0) && (32'(bin_index_i) < NUM_BINS);

  lbpm_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BINS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (cmd_i.take),
    .raddr_i (bin_index_i),
    .rdata_o (map_rdata)
  );

  lbpm_ram #(.WIDTH(MAG_WIDTH), .DEPTH(STAT_DEPTH)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  lbpm_ram #(.WIDTH(PEAK_W), .DEPTH(STAT_DEPTH)) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (pk_we),
    .waddr_i (pk_waddr),
    .wdata_i (pk_wdata),
    .re_i    (cmd_i.f_rd),
    .raddr_i ({ch_q, band_q}),
    .rdata_o (pk_rdata)
  );

  // shared scaler: (x * f + half) >> 16
  logic [MAG_WIDTH-1:0] peak_q, level_q, dec_q, mul_a;
  logic [HOLD_W-1:0]    hold_q;
  logic [COEF_W-1:0]    mul_f;
  logic [PROD_W-1:0]    prod;

  assign mul_a = cmd_i.f_lvl ? acc_rdata : peak_q;
  assign mul_f = cmd_i.f_lvl ? level_scale_q : peak_decay_q;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_f) + ROUND_HALF;

  // peak update
  logic [HOLD_W-1:0]    hold_dec, new_hold;
  logic [MAG_WIDTH-1:0] new_peak;

  always_comb begin
    hold_dec = (hold_q != '0) ? hold_q - HOLD_W'(1) : '0;
    if (level_q > peak_q) begin
      new_peak = level_q;
      new_hold = hold_frames_q;
    end else begin
      new_hold = hold_dec;
      if (hold_dec == '0) begin
        new_peak = (dec_q > level_q) ? dec_q : level_q;
      end else begin
        new_peak = peak_q;
      end
    end
  end

  // memory port steering
  always_comb begin
    map_we    = 1'b0;
    map_waddr = bin_index_i;
    map_wdata = band_entry_i;
    acc_we    = 1'b0;
    acc_waddr = {ch_q, band_q};
    acc_wdata = '0;
    pk_we     = 1'b0;
    pk_waddr  = {ch_q, band_q};
    pk_wdata  = {new_hold, new_peak};
    if (cmd_i.clr_step) begin
      map_we    = 32'(clr_q) < NUM_BINS;
      map_waddr = clr_q[BIN_W-1:0];
      map_wdata = OUT_OF_RANGE;
      acc_we    = 32'(clr_q) < STAT_DEPTH;
      acc_waddr = clr_q[STAT_AW-1:0];
      pk_we     = acc_we;
      pk_waddr  = clr_q[STAT_AW-1:0];
      pk_wdata  = '0;
    end else if (cmd_i.take) begin
      map_we = (operation_i == OP_MAP_WRITE) && (32'(bin_index_i) < NUM_BINS);
    end else if (cmd_i.acc_wr) begin
      acc_we    = hit_q && (mag_q > acc_rdata);
      acc_waddr = acc_addr_q;
      acc_wdata = mag_q;
    end else if (cmd_i.f_upd) begin
      acc_we = 1'b1;
      pk_we  = 1'b1;
    end
  end

  assign acc_re    = cmd_i.acc_rd || cmd_i.f_rd;
  assign acc_raddr = cmd_i.acc_rd ? {ch_q, map_rdata[BW-1:0]} : {ch_q, band_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ch_q     <= channel_i;
      mag_q    <= magnitude_i;
      fend_q   <= frame_end_i;
      bin_ok_q <= bin_ok_in;
    end
    if (cmd_i.acc_rd) begin
      hit_q      <= bin_ok_q && (map_rdata < OUT_OF_RANGE);
      acc_addr_q <= {ch_q, map_rdata[BW-1:0]};
    end
    if (cmd_i.f_lvl) begin
      level_q <= prod[PROD_W-1:COEF_W];
      peak_q  <= pk_rdata[MAG_WIDTH-1:0];
      hold_q  <= pk_rdata[PEAK_W-1:MAG_WIDTH];
    end
    if (cmd_i.f_dec) begin
      dec_q <= prod[PROD_W-1:COEF_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= '0;
    end else if (cmd_i.take) begin
      band_q <= '0;
    end else if (cmd_i.f_upd) begin
      band_q <= band_q + BW'(1);
    end
  end

  // output register
  logic out_valid_q, out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.f_upd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.f_upd) begin
      out_channel_o <= ch_q;
      band_number_o <= BANDNUM_W'(band_q);
      band_level_o  <= level_q;
      band_peak_o   <= new_peak;
      last_band_o   <= sts_o.band_last;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.clr_done  = (clr_q == CLR_W'(CLR_DEPTH - 1));
  assign sts_o.in_mag    = (operation_i == OP_MAGNITUDE);
  assign sts_o.frame_end = fend_q;
  assign sts_o.band_last = (band_q == BW'(NUM_BANDS - 1));
  assign sts_o.out_free  = out_free;

endmodule
`default_nettype wire

[design/log_band_peak_hold_meter.sv]
// top level of the log band peak hold meter
//
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_ready_o  operation, channel, bin_index, band_entry,
//                                             magnitude, frame_end
//  out      source     out_valid_o/out_ready_i out_channel, band_number, band_level,
//                                             band_peak, last_band
//  cfg      sink       cfg_we_i               cfg_index_i, cfg_wdata_i
//
// a map write is done as it is taken, a magnitude word by a map ram read, then a band
// ram read-modify-write. a frame end walks each band through a read, level scaling,
// decay scaling and an update, as the scaler multiplier is shared and each ram has one read port.
// after reset a clearing pass over max(NUM_BINS, 2 * 2**clog2(NUM_BANDS)) addresses
// (512 by default) fills the map and zeroes the band rams; no word is taken meanwhile.
// the band walk pauses while the output register holds a word not yet taken.
`default_nettype none
module log_band_peak_hold_meter #(
  parameter int NUM_BANDS = 32,
  parameter int NUM_BINS  = 512,
  parameter int MAG_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lbpm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [lbpm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             operation_i,
  input  wire logic                             channel_i,
  input  wire logic [$clog2(NUM_BINS)-1:0]      bin_index_i,
  input  wire logic [lbpm_pkg::ENTRY_W-1:0]     band_entry_i,
  input  wire logic [MAG_WIDTH-1:0]             magnitude_i,
  input  wire logic                             frame_end_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_channel_o,
  output logic      [lbpm_pkg::BANDNUM_W-1:0]   band_number_o,
  output logic      [MAG_WIDTH-1:0]             band_level_o,
  output logic      [MAG_WIDTH-1:0]             band_peak_o,
  output logic                                  last_band_o
);
  import lbpm_pkg::*;

  lbpm_cmd_t cmd;
  lbpm_sts_t sts;

  lbpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbpm_dp #(
    .NUM_BANDS (NUM_BANDS),
    .NUM_BINS  (NUM_BINS),
    .MAG_WIDTH (MAG_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .channel_i     (channel_i),
    .bin_index_i   (bin_index_i),
    .band_entry_i  (band_entry_i),
    .magnitude_i   (magnitude_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_channel_o (out_channel_o),
    .band_number_o (band_number_o),
    .band_level_o  (band_level_o),
    .band_peak_o   (band_peak_o),
    .last_band_o   (last_band_o)
  );

endmodule
`default_nettype wire
